[src/bezier_outline_flattener_defines.svh]
// assertion macros shared by the outline flattener rtl
`ifndef BEZIER_OUTLINE_FLATTENER_DEFINES_SVH
`define BEZIER_OUTLINE_FLATTENER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define BOF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bof assertion failed");

// next-cycle implication, disabled while in reset
`define BOF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bof assertion failed");

`endif

[src/bof_pkg.sv]
// shared types and constants for the outline flattener
package bof_pkg;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [15:0] c0_x;
    logic signed [15:0] c0_y;
    logic signed [15:0] c1_x;
    logic signed [15:0] c1_y;
    logic signed [15:0] c2_x;
    logic signed [15:0] c2_y;
  } req_t;

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic               last;
  } resp_t;

  // command codes
  localparam logic [1:0] REQ_MOVE  = 2'd0;
  localparam logic [1:0] REQ_LINE  = 2'd1;
  localparam logic [1:0] REQ_QUAD  = 2'd2;
  localparam logic [1:0] REQ_CUBIC = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_SCALE    = 2'd0;
  localparam logic [1:0] REG_OFFSET_X = 2'd1;
  localparam logic [1:0] REG_OFFSET_Y = 2'd2;

  // datapath widths (sized for up to 64 segments)
  localparam int MUL_W  = 24;
  localparam int PROD_W = 48;
  localparam int NUM_W  = 41;
  localparam int DEN_W  = 21;
  localparam int QUOT_W = 16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP,
    ST_DIFF,
    ST_SQ,
    ST_SEG,
    ST_COEF,
    ST_SUM,
    ST_DIV,
    ST_PUT
  } state_t;

endpackage

[src/bof_div.sv]
// restoring divider, one quotient bit per cycle
module bof_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [bof_pkg::NUM_W-1:0]  num,
  input  logic [bof_pkg::DEN_W-1:0]  den,
  output logic                       done,
  output logic [bof_pkg::QUOT_W-1:0] quot
);

  logic                      active;
  logic [3:0]                bitc;
  logic [bof_pkg::NUM_W-1:0] rem;
  logic [bof_pkg::DEN_W-1:0] dreg;
  logic [bof_pkg::NUM_W-1:0] trial;
  logic                      fits;

  // shifted divisor for the current quotient bit
  always_comb begin
    trial = bof_pkg::NUM_W'(dreg) << bitc;
    fits  = rem >= trial;
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      bitc   <= '0;
    end else if (start) begin
      active <= 1'b1;
      done   <= 1'b0;
      bitc   <= 4'd15;
    end else if (active) begin
      if (bitc == 4'd0) begin
        active <= 1'b0;
        done   <= 1'b1;
      end else begin
        bitc <= bitc - 4'd1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num;
      dreg <= den;
    end else if (active) begin
      quot[bitc] <= fits;
      if (fits) begin
        rem <= rem - trial;
      end
    end
  end

endmodule

[src/bezier_outline_flattener.sv]
// outline flattener: maps outline commands to polygon vertices
// Usage: a command (move, line, quadratic or cubic) enters on the req channel
// when req_valid is high and req_stall low. Vertices leave on the pt channel,
// one transaction each, with pt.last set on the final vertex of the command.
// Configuration (scale, offsets) is written through cfg_we/cfg_index/cfg_data;
// the user must write it only while the block is idle; the block has no check for it.
// Datapath: one shared 24x24 multiplier and a 16-step divider do all the work.
// A move or line maps its points, then puts its vertex in the output register.
// A curve maps its points and computes its deviation, then chooses n by counting
// up from 1 until the deviation test passes or n reaches MAX_SEGMENTS, then for
// each vertex computes coefficients, two weighted sums and two divides.
// req_stall is high from acceptance until the last vertex is in the output
// register; one command is processed at a time.
// Reset clears the current point to (0, 0), scale to 1.0 and offsets to 0.
// When pt_stall is high the output register holds its vertex and the
// sequencer waits before loading the next one.
module bezier_outline_flattener #(
  parameter int MAX_SEGMENTS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  bof_pkg::req_t         req,
  output logic                  pt_valid,
  input  logic                  pt_stall,
  output bof_pkg::resp_t        pt,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_data
);

  `include "bezier_outline_flattener_defines.svh"

  localparam int NW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [NW-1:0] N_MAX = NW'(MAX_SEGMENTS);

  bof_pkg::state_t state, state_next;
  logic [3:0] step, step_next;
  logic       ph, ph_next;

  logic [15:0]        scale;
  logic signed [15:0] off_x, off_y, cur_x, cur_y;
  logic signed [15:0] raw [6];
  logic [1:0]         typ;
  logic signed [15:0] px [4];
  logic signed [15:0] py [4];
  logic signed [17:0] dif [4];
  logic [35:0]        a2, b2;
  logic [39:0]        wm2;
  logic [NW-1:0]      n, k, u;
  logic [12:0]        n2, uu, tt;
  logic [19:0]        c [4];
  logic [19:0]        den;
  logic signed [37:0] acc;
  logic               ax;
  logic signed [15:0] qx, qy;
  logic               last_r;

  logic signed [bof_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [bof_pkg::PROD_W-1:0] mul_p;

  logic                      acc_in, load_out, seg_hit, div_start, div_done;
  logic [1:0]                last_idx;
  logic signed [33:0]        map_r;
  logic signed [22:0]        map_s;
  logic signed [15:0]        map_v;
  logic [35:0]               m2;
  logic [40:0]               seg_lhs;
  logic signed [40:0]        acc_w, den_w, dnum;
  logic [bof_pkg::QUOT_W-1:0] div_q;

  assign acc_in    = req_valid && !req_stall;
  assign req_stall = (state != bof_pkg::ST_IDLE);
  assign load_out  = !pt_valid || !pt_stall;
  assign u         = n - k;
  assign last_idx  = (typ == bof_pkg::REQ_QUAD) ? 2'd2 : 2'd3;

  // point mapping: round to nearest, add offset, saturate
  always_comb begin
    map_r = $signed(mul_p[33:0]) + 34'sd2048;
    map_s = 23'($signed(map_r[33:12])) + 23'(step[0] ? off_y : off_x);
    if (map_s > 23'sd32767) begin
      map_v = 16'sh7fff;
    end else if (map_s < -23'sd32768) begin
      map_v = -16'sh8000;
    end else begin
      map_v = map_s[15:0];
    end
  end

  // segment count test
  always_comb begin
    m2      = (typ == bof_pkg::REQ_CUBIC && b2 > a2) ? b2 : a2;
    seg_lhs = {mul_p[32:0], 8'b0};
    seg_hit = seg_lhs >= {1'b0, wm2};
  end

  // biased numerator for a floor division of 2*acc+den by 2*den
  always_comb begin
    acc_w = {{3{acc[37]}}, acc};
    den_w = {21'b0, den};
    dnum  = (acc_w <<< 1) + den_w + (den_w <<< 16);
  end

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      bof_pkg::ST_MAP: begin
        mul_a = {{8{raw[step[2:0]][15]}}, raw[step[2:0]]};
        mul_b = {8'b0, scale};
      end
      bof_pkg::ST_SQ: begin
        mul_a = {{6{dif[step[1:0]][17]}}, dif[step[1:0]]};
        mul_b = {{6{dif[step[1:0]][17]}}, dif[step[1:0]]};
      end
      bof_pkg::ST_SEG: begin
        if (step == 4'd1) begin
          mul_a = {{(bof_pkg::MUL_W-NW){1'b0}}, n};
          mul_b = {{(bof_pkg::MUL_W-NW){1'b0}}, n};
        end else begin
          mul_a = {11'b0, n2};
          mul_b = {11'b0, n2};
        end
      end
      bof_pkg::ST_COEF: begin
        case (step)
          4'd0: begin
            mul_a = {{(bof_pkg::MUL_W-NW){1'b0}}, u};
            mul_b = {{(bof_pkg::MUL_W-NW){1'b0}}, u};
          end
          4'd1: begin
            mul_a = {{(bof_pkg::MUL_W-NW){1'b0}}, k};
            mul_b = {{(bof_pkg::MUL_W-NW){1'b0}}, k};
          end
          4'd2: begin
            mul_a = {{(bof_pkg::MUL_W-NW){1'b0}}, u};
            mul_b = {{(bof_pkg::MUL_W-NW){1'b0}}, k};
          end
          4'd3: begin
            mul_a = {11'b0, uu};
            mul_b = {{(bof_pkg::MUL_W-NW){1'b0}}, u};
          end
          4'd4: begin
            mul_a = {11'b0, uu};
            mul_b = {{(bof_pkg::MUL_W-NW){1'b0}}, k};
          end
          4'd5: begin
            mul_a = {11'b0, tt};
            mul_b = {{(bof_pkg::MUL_W-NW){1'b0}}, u};
          end
          4'd6: begin
            mul_a = {11'b0, tt};
            mul_b = {{(bof_pkg::MUL_W-NW){1'b0}}, k};
          end
          default: begin
            mul_a = {11'b0, n2};
            mul_b = {{(bof_pkg::MUL_W-NW){1'b0}}, n};
          end
        endcase
      end
      bof_pkg::ST_SUM: begin
        mul_a = {4'b0, c[step[1:0]]};
        mul_b = ax ? {{8{py[step[1:0]][15]}}, py[step[1:0]]}
                   : {{8{px[step[1:0]][15]}}, px[step[1:0]]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bof_pkg::ST_IDLE;
      step  <= '0;
      ph    <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      ph    <= ph_next;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    step_next  = step;
    ph_next    = ph;
    div_start  = 1'b0;
    unique case (state)
      bof_pkg::ST_IDLE: begin
        if (acc_in) begin
          state_next = bof_pkg::ST_MAP;
          step_next  = '0;
          ph_next    = 1'b0;
        end
      end
      bof_pkg::ST_MAP: begin
        ph_next = ~ph;
        if (ph) begin
          if (step == 4'd5) begin
            step_next  = '0;
            state_next = (typ == bof_pkg::REQ_MOVE || typ == bof_pkg::REQ_LINE)
                         ? bof_pkg::ST_PUT : bof_pkg::ST_DIFF;
          end else begin
            step_next = step + 4'd1;
          end
        end
      end
      bof_pkg::ST_DIFF: begin
        state_next = bof_pkg::ST_SQ;
        step_next  = '0;
        ph_next    = 1'b0;
      end
      bof_pkg::ST_SQ: begin
        ph_next = ~ph;
        if (ph) begin
          if ((step == 4'd1 && typ == bof_pkg::REQ_QUAD) || step == 4'd3) begin
            state_next = bof_pkg::ST_SEG;
            step_next  = '0;
          end else begin
            step_next = step + 4'd1;
          end
        end
      end
      bof_pkg::ST_SEG: begin
        ph_next = 1'b0;
        if (step == 4'd4) begin
          if (seg_hit || n == N_MAX) begin
            state_next = bof_pkg::ST_COEF;
            step_next  = '0;
          end else begin
            step_next = 4'd1;
          end
        end else begin
          step_next = step + 4'd1;
        end
      end
      bof_pkg::ST_COEF: begin
        ph_next = ~ph;
        if (ph) begin
          if ((typ == bof_pkg::REQ_QUAD && step == 4'd2) || step == 4'd7) begin
            state_next = bof_pkg::ST_SUM;
            step_next  = '0;
          end else begin
            step_next = step + 4'd1;
          end
        end
      end
      bof_pkg::ST_SUM: begin
        ph_next = ~ph;
        if (ph) begin
          if (step[1:0] == last_idx) begin
            state_next = bof_pkg::ST_DIV;
            step_next  = '0;
          end else begin
            step_next = step + 4'd1;
          end
        end
      end
      bof_pkg::ST_DIV: begin
        if (!ph) begin
          div_start = 1'b1;
          ph_next   = 1'b1;
        end else if (div_done) begin
          ph_next    = 1'b0;
          step_next  = '0;
          state_next = ax ? bof_pkg::ST_PUT : bof_pkg::ST_SUM;
        end
      end
      bof_pkg::ST_PUT: begin
        if (load_out) begin
          step_next  = '0;
          ph_next    = 1'b0;
          state_next = last_r ? bof_pkg::ST_IDLE : bof_pkg::ST_COEF;
        end
      end
      default: begin
        state_next = bof_pkg::ST_IDLE;
      end
    endcase
  end

  // configuration and current point
  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= 16'd4096;
      off_x <= '0;
      off_y <= '0;
      cur_x <= '0;
      cur_y <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          bof_pkg::REG_SCALE:    scale <= cfg_data;
          bof_pkg::REG_OFFSET_X: off_x <= cfg_data;
          bof_pkg::REG_OFFSET_Y: off_y <= cfg_data;
          default: ;
        endcase
      end
      if (state == bof_pkg::ST_PUT && load_out && last_r) begin
        cur_x <= px[typ == bof_pkg::REQ_MOVE || typ == bof_pkg::REQ_LINE ? 2'd1 : last_idx];
        cur_y <= py[typ == bof_pkg::REQ_MOVE || typ == bof_pkg::REQ_LINE ? 2'd1 : last_idx];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pt_valid <= 1'b0;
    end else if (state == bof_pkg::ST_PUT && load_out) begin
      pt_valid <= 1'b1;
    end else if (!pt_stall) begin
      pt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == bof_pkg::ST_PUT && load_out) begin
      pt.point_x <= qx;
      pt.point_y <= qy;
      pt.last    <= last_r;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      bof_pkg::ST_IDLE: begin
        if (acc_in) begin
          typ    <= req.req_type;
          raw[0] <= req.c0_x;
          raw[1] <= req.c0_y;
          raw[2] <= req.c1_x;
          raw[3] <= req.c1_y;
          raw[4] <= req.c2_x;
          raw[5] <= req.c2_y;
          px[0]  <= cur_x;
          py[0]  <= cur_y;
        end
      end
      bof_pkg::ST_MAP: begin
        if (ph) begin
          if (step[0]) begin
            py[2'(step[2:1] + 2'd1)] <= map_v;
          end else begin
            px[2'(step[2:1] + 2'd1)] <= map_v;
          end
          if (step == 4'd5) begin
            qx     <= px[1];
            qy     <= py[1];
            last_r <= 1'b1;
          end
        end
      end
      bof_pkg::ST_DIFF: begin
        dif[0] <= 18'(px[0]) - (18'(px[1]) <<< 1) + 18'(px[2]);
        dif[1] <= 18'(py[0]) - (18'(py[1]) <<< 1) + 18'(py[2]);
        dif[2] <= 18'(px[1]) - (18'(px[2]) <<< 1) + 18'(px[3]);
        dif[3] <= 18'(py[1]) - (18'(py[2]) <<< 1) + 18'(py[3]);
        n      <= NW'(1);
      end
      bof_pkg::ST_SQ: begin
        if (ph) begin
          case (step[1:0])
            2'd0:    a2 <= mul_p[35:0];
            2'd1:    a2 <= a2 + mul_p[35:0];
            2'd2:    b2 <= mul_p[35:0];
            default: b2 <= b2 + mul_p[35:0];
          endcase
        end
      end
      bof_pkg::ST_SEG: begin
        case (step)
          4'd0: wm2 <= (typ == bof_pkg::REQ_CUBIC) ? ({m2, 3'b0} + 40'(m2)) : 40'(m2);
          4'd2: n2  <= mul_p[12:0];
          4'd4: begin
            if (seg_hit || n == N_MAX) begin
              k <= NW'(1);
            end else begin
              n <= n + NW'(1);
            end
          end
          default: ;
        endcase
      end
      bof_pkg::ST_COEF: begin
        ax <= 1'b0;
        if (ph) begin
          case (step)
            4'd0: uu <= mul_p[12:0];
            4'd1: tt <= mul_p[12:0];
            4'd2: begin
              if (typ == bof_pkg::REQ_QUAD) begin
                c[0] <= 20'(uu);
                c[1] <= {mul_p[18:0], 1'b0};
                c[2] <= 20'(tt);
                c[3] <= '0;
                den  <= 20'(n2);
              end
            end
            4'd3: c[0] <= mul_p[19:0];
            4'd4: c[1] <= mul_p[19:0] + {mul_p[18:0], 1'b0};
            4'd5: c[2] <= mul_p[19:0] + {mul_p[18:0], 1'b0};
            4'd6: c[3] <= mul_p[19:0];
            default: den <= mul_p[19:0];
          endcase
        end
      end
      bof_pkg::ST_SUM: begin
        if (ph) begin
          acc <= ((step == 4'd0) ? 38'sd0 : acc) + mul_p[37:0];
        end
      end
      bof_pkg::ST_DIV: begin
        if (ph && div_done) begin
          if (!ax) begin
            qx <= div_q ^ 16'h8000;
            ax <= 1'b1;
          end else begin
            qy     <= div_q ^ 16'h8000;
            last_r <= (k == n);
          end
        end
      end
      bof_pkg::ST_PUT: begin
        if (load_out && !last_r) begin
          k <= k + NW'(1);
        end
      end
      default: ;
    endcase
  end

  bof_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (dnum),
    .den   ({1'b0, den} <<< 1),
    .done  (div_done),
    .quot  (div_q)
  );

  `BOF_ASSERT_NXT(a_accept_busy, req_valid && !req_stall, state != bof_pkg::ST_IDLE)
  `BOF_ASSERT_IMP(a_seg_range, state == bof_pkg::ST_COEF, n >= NW'(1) && n <= N_MAX)
  `BOF_ASSERT_IMP(a_mid_busy, pt_valid && !pt.last, state != bof_pkg::ST_IDLE)

endmodule
